// ===== hdl/line_color_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// Line color classifier assertion macros
// Concurrent assertion helpers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINE_COLOR_CLASSIFIER_ASSERT_SVH
`define LINE_COLOR_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF

// General property check.
`define LCC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("line_color_classifier: property check failed");

// Same-cycle implication check.
`define LCC_ASSERT_IMPL(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error("line_color_classifier: implication check failed");

`else

`define LCC_ASSERT(label, prop)
`define LCC_ASSERT_IMPL(label, cond, conseq)

`endif

`endif

// ===== hdl/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Line color classifier package
// Widths, color codes, register indexes and shared types for the classifier.
// ----------------------------------------------------------------------------
package lcc_pkg;

	localparam int SENSOR_W          = 12;
	localparam int CODE_W            = 3;
	localparam int CFG_IDX_W         = 4;
	localparam int HISTORY_DEPTH_DEF = 5;
	localparam int QUEUE_DEPTH       = 2;

	// Fixed upper bound of the black window.
	localparam logic [SENSOR_W-1:0] BLACK_HIGH = 12'd1500;

	// Floor color classes.
	typedef enum logic [CODE_W-1:0] {
		COLOR_WHITE      = 3'd0,
		COLOR_BROWN      = 3'd1,
		COLOR_GRAY_LEFT  = 3'd2,
		COLOR_GRAY_RIGHT = 3'd3,
		COLOR_GRAY_BOTH  = 3'd4,
		COLOR_GREEN      = 3'd5,
		COLOR_BLACK      = 3'd6,
		COLOR_NONE       = 3'd7
	} lcc_color_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WHITE_MAX  = 4'd0,
		CFG_BROWN_LOW  = 4'd1,
		CFG_BROWN_HIGH = 4'd2,
		CFG_GRAY_LOW   = 4'd3,
		CFG_GRAY_HIGH  = 4'd4,
		CFG_GREEN_LOW  = 4'd5,
		CFG_GREEN_HIGH = 4'd6,
		CFG_BLACK_LOW  = 4'd7
	} lcc_cfg_idx_t;

	// Threshold register file.
	typedef struct packed {
		logic [SENSOR_W-1:0] white_max;
		logic [SENSOR_W-1:0] brown_low;
		logic [SENSOR_W-1:0] brown_high;
		logic [SENSOR_W-1:0] gray_low;
		logic [SENSOR_W-1:0] gray_high;
		logic [SENSOR_W-1:0] green_low;
		logic [SENSOR_W-1:0] green_high;
		logic [SENSOR_W-1:0] black_low;
	} lcc_cfg_t;

	// Write side of the class queue.
	typedef struct packed {
		logic       push;
		lcc_color_t code;
	} lcc_q_wr_t;

	// Read side of the class queue.
	typedef struct packed {
		logic       valid;
		lcc_color_t code;
	} lcc_q_rd_t;

	// Inclusive window test; an inverted window matches nothing.
	function automatic logic in_window(input logic [SENSOR_W-1:0] lo,
			input logic [SENSOR_W-1:0] hi, input logic [SENSOR_W-1:0] v);
		return (v >= lo) && (v <= hi);
	endfunction

endpackage

// ===== hdl/lcc_if.sv =====
// ----------------------------------------------------------------------------
// Line color classifier channels
// Valid/ready interfaces for the sensor, result and configuration channels.
// ----------------------------------------------------------------------------

// Sensor sample set channel.
interface lcc_in_if;
	logic                          valid;
	logic                          ready;
	logic [lcc_pkg::SENSOR_W-1:0]  sensor_left;
	logic [lcc_pkg::SENSOR_W-1:0]  sensor_mid_left;
	logic [lcc_pkg::SENSOR_W-1:0]  sensor_center;
	logic [lcc_pkg::SENSOR_W-1:0]  sensor_mid_right;
	logic [lcc_pkg::SENSOR_W-1:0]  sensor_right;

	modport source (
		output valid, sensor_left, sensor_mid_left, sensor_center,
			sensor_mid_right, sensor_right,
		input  ready
	);
	modport sink (
		input  valid, sensor_left, sensor_mid_left, sensor_center,
			sensor_mid_right, sensor_right,
		output ready
	);
endinterface

// Classification result channel.
interface lcc_out_if;
	logic                        valid;
	logic                        ready;
	logic [lcc_pkg::CODE_W-1:0]  color_class;
	logic [lcc_pkg::CODE_W-1:0]  held_status;
	logic [lcc_pkg::CODE_W-1:0]  confirmed_color;

	modport source (
		output valid, color_class, held_status, confirmed_color,
		input  ready
	);
	modport sink (
		input  valid, color_class, held_status, confirmed_color,
		output ready
	);
endinterface

// Configuration write channel.
interface lcc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lcc_pkg::CFG_IDX_W-1:0]  index;
	logic [lcc_pkg::SENSOR_W-1:0]   data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== hdl/lcc_front.sv =====
// ----------------------------------------------------------------------------
// Line color classifier front end
// Holds the threshold registers, accepts sensor words and classifies them.
// ----------------------------------------------------------------------------
module lcc_front (
	input  logic              clk,
	input  logic              arst_n,
	lcc_in_if.sink            sensors,
	lcc_cfg_if.sink           cfg,
	input  logic              q_full,
	output lcc_pkg::lcc_q_wr_t q_wr
);
	import lcc_pkg::*;

	lcc_cfg_t   cfg_q;
	lcc_color_t code;
	logic       white_hit;
	logic       brown_hit;
	logic       gray_l;
	logic       gray_r;
	logic       green_hit;
	logic       black_hit;

	// Configuration writes are always taken; indexes past the list are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_WHITE_MAX:  cfg_q.white_max  <= cfg.data;
				CFG_BROWN_LOW:  cfg_q.brown_low  <= cfg.data;
				CFG_BROWN_HIGH: cfg_q.brown_high <= cfg.data;
				CFG_GRAY_LOW:   cfg_q.gray_low   <= cfg.data;
				CFG_GRAY_HIGH:  cfg_q.gray_high  <= cfg.data;
				CFG_GREEN_LOW:  cfg_q.green_low  <= cfg.data;
				CFG_GREEN_HIGH: cfg_q.green_high <= cfg.data;
				CFG_BLACK_LOW:  cfg_q.black_low  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Window tests on each sensor group.
	always_comb begin
		white_hit = (sensors.sensor_left      < cfg_q.white_max) &&
		            (sensors.sensor_mid_left  < cfg_q.white_max) &&
		            (sensors.sensor_center    < cfg_q.white_max) &&
		            (sensors.sensor_mid_right < cfg_q.white_max) &&
		            (sensors.sensor_right     < cfg_q.white_max);
		brown_hit = in_window(cfg_q.brown_low, cfg_q.brown_high, sensors.sensor_left) &&
		            in_window(cfg_q.brown_low, cfg_q.brown_high, sensors.sensor_mid_left) &&
		            in_window(cfg_q.brown_low, cfg_q.brown_high, sensors.sensor_center) &&
		            in_window(cfg_q.brown_low, cfg_q.brown_high, sensors.sensor_mid_right) &&
		            in_window(cfg_q.brown_low, cfg_q.brown_high, sensors.sensor_right);
		gray_l    = in_window(cfg_q.gray_low, cfg_q.gray_high, sensors.sensor_left);
		gray_r    = in_window(cfg_q.gray_low, cfg_q.gray_high, sensors.sensor_right);
		green_hit = in_window(cfg_q.green_low, cfg_q.green_high, sensors.sensor_mid_left) ||
		            in_window(cfg_q.green_low, cfg_q.green_high, sensors.sensor_center) ||
		            in_window(cfg_q.green_low, cfg_q.green_high, sensors.sensor_mid_right);
		black_hit = in_window(cfg_q.black_low, BLACK_HIGH, sensors.sensor_mid_left) ||
		            in_window(cfg_q.black_low, BLACK_HIGH, sensors.sensor_center) ||
		            in_window(cfg_q.black_low, BLACK_HIGH, sensors.sensor_mid_right);
	end

	// Fixed priority: white, brown, gray, green, black.
	always_comb begin
		if (white_hit) begin
			code = COLOR_WHITE;
		end else if (brown_hit) begin
			code = COLOR_BROWN;
		end else if (gray_l && !gray_r) begin
			code = COLOR_GRAY_LEFT;
		end else if (gray_r && !gray_l) begin
			code = COLOR_GRAY_RIGHT;
		end else if (gray_l && gray_r) begin
			code = COLOR_GRAY_BOTH;
		end else if (green_hit) begin
			code = COLOR_GREEN;
		end else if (black_hit) begin
			code = COLOR_BLACK;
		end else begin
			code = COLOR_NONE;
		end
	end

	// A word is taken whenever the queue has room.
	assign sensors.ready = !q_full;
	assign q_wr.push     = sensors.valid && !q_full;
	assign q_wr.code     = code;

endmodule

// ===== hdl/lcc_queue.sv =====
// ----------------------------------------------------------------------------
// Line color classifier class queue
// Short FIFO of class codes between the front end and the history back end.
// ----------------------------------------------------------------------------
module lcc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  lcc_pkg::lcc_q_wr_t q_wr,
	output logic               q_full,
	output lcc_pkg::lcc_q_rd_t q_rd,
	input  logic               pop
);
	import lcc_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lcc_color_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign q_full    = (count_q == CNT_W'(DEPTH));
	assign q_rd.valid = (count_q != '0);
	assign q_rd.code  = mem_q[rd_ptr_q];
	assign do_push   = q_wr.push && !q_full;
	assign do_pop    = pop && q_rd.valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.code;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/lcc_back.sv =====
// ----------------------------------------------------------------------------
// Line color classifier back end
// Updates status, history ring and confirmed color, and drives the result word.
// ----------------------------------------------------------------------------
module lcc_back #(
	parameter int HISTORY_DEPTH = lcc_pkg::HISTORY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lcc_pkg::lcc_q_rd_t q_rd,
	output logic               pop,
	lcc_out_if.source          results
);
	import lcc_pkg::*;

	localparam int SLOT_W = $clog2(HISTORY_DEPTH);

	lcc_color_t        ring_q [HISTORY_DEPTH];
	lcc_color_t        ring_n [HISTORY_DEPTH];
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_n;
	lcc_color_t        last_q;
	lcc_color_t        last_n;
	lcc_color_t        stable_q;
	lcc_color_t        stable_n;
	logic              matched;
	logic              all_same;
	logic              out_valid_q;
	lcc_color_t        out_class_q;
	lcc_color_t        out_held_q;
	lcc_color_t        out_conf_q;

	// Take the next code whenever the result register is free or being drained.
	assign pop     = q_rd.valid && (!out_valid_q || results.ready);
	assign matched = (q_rd.code != COLOR_NONE);

	// Next state: push a matched code and check whether the ring agrees.
	always_comb begin
		ring_n   = ring_q;
		slot_n   = slot_q;
		last_n   = last_q;
		stable_n = stable_q;
		all_same = 1'b1;
		if (matched) begin
			ring_n[slot_q] = q_rd.code;
			slot_n = (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
			last_n = q_rd.code;
		end
		for (int i = 1; i < HISTORY_DEPTH; i++) begin
			if (ring_n[i] != ring_n[0]) begin
				all_same = 1'b0;
			end
		end
		if (matched && all_same) begin
			stable_n = ring_n[0];
		end
	end

	// History state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q   <= '{default: COLOR_NONE};
			slot_q   <= '0;
			last_q   <= COLOR_NONE;
			stable_q <= COLOR_NONE;
		end else if (pop) begin
			ring_q   <= ring_n;
			slot_q   <= slot_n;
			last_q   <= last_n;
			stable_q <= stable_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_class_q <= q_rd.code;
			out_held_q  <= last_n;
			out_conf_q  <= stable_n;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.color_class     = out_class_q;
	assign results.held_status     = out_held_q;
	assign results.confirmed_color = out_conf_q;

endmodule

// ===== hdl/line_color_classifier.sv =====
// ----------------------------------------------------------------------------
// Line color classifier: one sensor word per cycle while the queue has room.
// Classification in the front end, a two-entry queue, then a result register.
// The back end updates the history as it takes each code from the queue.
// Reset (arst_n low) clears thresholds to zero, history and status to code 7.
// ----------------------------------------------------------------------------
`include "line_color_classifier_assert.svh"

module line_color_classifier #(
	parameter int HISTORY_DEPTH = lcc_pkg::HISTORY_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lcc_in_if.sink    sensors,
	lcc_cfg_if.sink   cfg,
	lcc_out_if.source results
);
	import lcc_pkg::*;

	lcc_q_wr_t q_wr;
	lcc_q_rd_t q_rd;
	logic      q_full;
	logic      pop;

	// Front end: thresholds and classification.
	lcc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.sensors (sensors),
		.cfg     (cfg),
		.q_full  (q_full),
		.q_wr    (q_wr)
	);

	// Queue between classification and history update.
	lcc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_rd   (q_rd),
		.pop    (pop)
	);

	// Back end: history ring, status and result register.
	lcc_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_rd    (q_rd),
		.pop     (pop),
		.results (results)
	);

	// A word taken into an empty pipeline passes the queue and the result register, then shows up as a result.
	`LCC_ASSERT(a_latency, sensors.valid && sensors.ready && !q_rd.valid && (!results.valid || results.ready) |=> ##1 results.valid)

	// A matched class becomes the held status at once.
	`LCC_ASSERT_IMPL(a_held_follows, results.valid && (results.color_class != COLOR_NONE), results.held_status == results.color_class)

	// Nothing can be confirmed before any class has matched.
	`LCC_ASSERT_IMPL(a_conf_none, results.valid && (results.held_status == COLOR_NONE), results.confirmed_color == COLOR_NONE)

endmodule

// ===== verif/lcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line color classifier checker
// Watches the sensor, configuration and result channels, keeps its own copy of
// the thresholds and the color history, and compares every result word with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module lcc_checker #(
	parameter int HISTORY_DEPTH = lcc_pkg::HISTORY_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lcc_in_if         sensors,
	lcc_cfg_if        cfg,
	lcc_out_if        results,
	output int        fail_count,
	output int        pending,
	output int        checked,
	output logic [7:0] classes_seen
);
	import lcc_pkg::*;

	typedef struct packed {
		lcc_color_t color_class;
		lcc_color_t held_status;
		lcc_color_t confirmed_color;
	} floor_result_t;

	// Mirror of the block's thresholds and color history.
	lcc_cfg_t      thresholds;
	lcc_color_t    color_ring [HISTORY_DEPTH];
	int            ring_slot;
	lcc_color_t    held_color;
	lcc_color_t    steady_color;
	floor_result_t predicted_results [$];

	// Inclusive band test; a band with low above high holds nothing.
	function automatic bit in_band(input logic [SENSOR_W-1:0] lo,
			input logic [SENSOR_W-1:0] hi, input logic [SENSOR_W-1:0] v);
		return (v >= lo) && (v <= hi);
	endfunction

	// Reports one result field that differs from its prediction.
	function automatic int field_differs(input string field, input lcc_color_t want,
			input logic [CODE_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [SENSOR_W-1:0] rd [5];
		lcc_color_t          code;
		floor_result_t       want;
		bit                  white_all;
		bit                  brown_all;
		bit                  gray_l;
		bit                  gray_r;
		bit                  green_hit;
		bit                  black_hit;
		bit                  same;
		if (!arst_n) begin
			thresholds = '0;
			for (int i = 0; i < HISTORY_DEPTH; i++)
				color_ring[i] = COLOR_NONE;
			ring_slot = 0;
			held_color = COLOR_NONE;
			steady_color = COLOR_NONE;
			predicted_results.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			classes_seen = '0;
		end else begin
			// Threshold writes; indexes past the last register are dropped.
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_WHITE_MAX:  thresholds.white_max = cfg.data;
					CFG_BROWN_LOW:  thresholds.brown_low = cfg.data;
					CFG_BROWN_HIGH: thresholds.brown_high = cfg.data;
					CFG_GRAY_LOW:   thresholds.gray_low = cfg.data;
					CFG_GRAY_HIGH:  thresholds.gray_high = cfg.data;
					CFG_GREEN_LOW:  thresholds.green_low = cfg.data;
					CFG_GREEN_HIGH: thresholds.green_high = cfg.data;
					CFG_BLACK_LOW:  thresholds.black_low = cfg.data;
					default: ;
				endcase
			end

			// Classify an accepted sensor word by fixed priority.
			if (sensors.valid && sensors.ready) begin
				rd[0] = sensors.sensor_left;
				rd[1] = sensors.sensor_mid_left;
				rd[2] = sensors.sensor_center;
				rd[3] = sensors.sensor_mid_right;
				rd[4] = sensors.sensor_right;
				white_all = 1'b1;
				brown_all = 1'b1;
				for (int i = 0; i < 5; i++) begin
					if (!(rd[i] < thresholds.white_max))
						white_all = 1'b0;
					if (!in_band(thresholds.brown_low, thresholds.brown_high, rd[i]))
						brown_all = 1'b0;
				end
				gray_l = in_band(thresholds.gray_low, thresholds.gray_high, rd[0]);
				gray_r = in_band(thresholds.gray_low, thresholds.gray_high, rd[4]);
				green_hit = 1'b0;
				black_hit = 1'b0;
				for (int i = 1; i <= 3; i++) begin
					if (in_band(thresholds.green_low, thresholds.green_high, rd[i]))
						green_hit = 1'b1;
					if (in_band(thresholds.black_low, BLACK_HIGH, rd[i]))
						black_hit = 1'b1;
				end
				if (white_all)
					code = COLOR_WHITE;
				else if (brown_all)
					code = COLOR_BROWN;
				else if (gray_l && !gray_r)
					code = COLOR_GRAY_LEFT;
				else if (gray_r && !gray_l)
					code = COLOR_GRAY_RIGHT;
				else if (gray_l && gray_r)
					code = COLOR_GRAY_BOTH;
				else if (green_hit)
					code = COLOR_GREEN;
				else if (black_hit)
					code = COLOR_BLACK;
				else
					code = COLOR_NONE;

				// A matched class updates the status and the history ring;
				// the confirmed color follows once every entry agrees.
				if (code != COLOR_NONE) begin
					held_color = code;
					color_ring[ring_slot] = code;
					ring_slot = (ring_slot + 1) % HISTORY_DEPTH;
					same = 1'b1;
					for (int i = 1; i < HISTORY_DEPTH; i++)
						if (color_ring[i] != color_ring[0])
							same = 1'b0;
					if (same)
						steady_color = color_ring[0];
				end
				classes_seen[code] = 1'b1;
				want.color_class = code;
				want.held_status = held_color;
				want.confirmed_color = steady_color;
				predicted_results.push_back(want);
			end

			// Compare an accepted result word with the oldest prediction.
			if (results.valid && results.ready) begin
				if (predicted_results.size() == 0) begin
					$error("result word with no sensor word outstanding: %0d %0d %0d",
						results.color_class, results.held_status, results.confirmed_color);
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					checked++;
					fail_count += field_differs("color_class", want.color_class,
						results.color_class);
					fail_count += field_differs("held_status", want.held_status,
						results.held_status);
					fail_count += field_differs("confirmed_color", want.confirmed_color,
						results.confirmed_color);
				end
			end
			pending = predicted_results.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line color classifier testbench
// Drives sensor words and threshold writes in bursts while the result side
// stalls on its own pattern; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import lcc_pkg::*;

	localparam int RANDOM_SETS    = 700;
	localparam int RANDOM_PHASES  = 8;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SENSOR_MAX     = (1 << SENSOR_W) - 1;

	typedef logic [SENSOR_W-1:0] reading_t;
	typedef reading_t sensor_set_t [5];

	// Pacing styles of the result side.
	typedef enum int {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_PERIODIC
	} sink_mode_t;

	logic        clk;
	logic        arst_n;
	int          fail_count;
	int          pending;
	int          checked;
	logic [7:0]  classes_seen;
	reading_t    th [8];
	int          burst_left;
	int          sets_sent;
	int          settings_used;
	int          idle_cycles;
	sink_mode_t  sink_mode;
	int          mode_left;
	int          stall_left;
	int          sink_tick;

	lcc_in_if  sensors_if ();
	lcc_cfg_if cfg_if ();
	lcc_out_if results_if ();

	line_color_classifier u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sensors (sensors_if),
		.cfg     (cfg_if),
		.results (results_if)
	);

	lcc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sensors      (sensors_if),
		.cfg          (cfg_if),
		.results      (results_if),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked),
		.classes_seen (classes_seen)
	);

	always #6 clk = ~clk;

	// Picks a reading inside a band, on its edges or just outside it.
	function automatic reading_t pick_in(input reading_t lo, input reading_t hi);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return lo;
		if (roll < 30)
			return hi;
		if (roll < 35)
			return lo - 1'b1;
		if (roll < 40)
			return hi + 1'b1;
		if (lo <= hi)
			return reading_t'($urandom_range(int'(lo), int'(hi)));
		return reading_t'($urandom_range(0, SENSOR_MAX));
	endfunction

	// A reading with no particular target: extremes, uniform or near a band.
	function automatic reading_t any_reading();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? reading_t'(SENSOR_MAX) : '0;
			1, 2: return reading_t'($urandom_range(0, SENSOR_MAX));
			3: return pick_in(th[CFG_BROWN_LOW], th[CFG_BROWN_HIGH]);
			4: return pick_in(th[CFG_GRAY_LOW], th[CFG_GRAY_HIGH]);
			default: return $urandom_range(0, 1) ?
				pick_in(th[CFG_GREEN_LOW], th[CFG_GREEN_HIGH]) :
				pick_in(th[CFG_BLACK_LOW], BLACK_HIGH);
		endcase
	endfunction

	// Shapes a sensor word that aims at one color class under the current
	// thresholds; aiming at no class gives plain noise.
	task automatic build_set(input lcc_color_t target, output sensor_set_t s);
		for (int i = 0; i < 5; i++)
			s[i] = any_reading();
		case (target)
			COLOR_WHITE: begin
				for (int i = 0; i < 5; i++)
					s[i] = (th[CFG_WHITE_MAX] == 0) ? reading_t'(0) :
						reading_t'($urandom_range(0, int'(th[CFG_WHITE_MAX]) - 1));
				if ($urandom_range(0, 3) == 0)
					s[$urandom_range(0, 4)] = th[CFG_WHITE_MAX];
			end
			COLOR_BROWN: begin
				for (int i = 0; i < 5; i++)
					s[i] = pick_in(th[CFG_BROWN_LOW], th[CFG_BROWN_HIGH]);
			end
			COLOR_GRAY_LEFT: s[0] = pick_in(th[CFG_GRAY_LOW], th[CFG_GRAY_HIGH]);
			COLOR_GRAY_RIGHT: s[4] = pick_in(th[CFG_GRAY_LOW], th[CFG_GRAY_HIGH]);
			COLOR_GRAY_BOTH: begin
				s[0] = pick_in(th[CFG_GRAY_LOW], th[CFG_GRAY_HIGH]);
				s[4] = pick_in(th[CFG_GRAY_LOW], th[CFG_GRAY_HIGH]);
			end
			COLOR_GREEN:
				s[$urandom_range(1, 3)] = pick_in(th[CFG_GREEN_LOW], th[CFG_GREEN_HIGH]);
			COLOR_BLACK:
				s[$urandom_range(1, 3)] = pick_in(th[CFG_BLACK_LOW], BLACK_HIGH);
			default: ;
		endcase
	endtask

	// Sends one sensor word; the sender runs in bursts with gaps between them.
	task automatic send_set(input reading_t l, input reading_t ml, input reading_t c,
			input reading_t mr, input reading_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: gap = 0;
				9: gap = $urandom_range(10, 30);
				default: gap = $urandom_range(1, 6);
			endcase
			if (gap > 0) begin
				@(negedge clk);
				sensors_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		sensors_if.valid <= 1'b1;
		sensors_if.sensor_left <= l;
		sensors_if.sensor_mid_left <= ml;
		sensors_if.sensor_center <= c;
		sensors_if.sensor_mid_right <= mr;
		sensors_if.sensor_right <= r;
		do @(posedge clk); while (!sensors_if.ready);
		sets_sent++;
	endtask

	// One register write; the local copy only tracks indexes that exist.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input reading_t val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx <= CFG_BLACK_LOW)
			th[idx] = val;
	endtask

	// Writes every threshold, then one write to an index past the last
	// register, which must leave the thresholds alone.
	task automatic load_thresholds(input reading_t wmax, input reading_t bl,
			input reading_t bh, input reading_t gl, input reading_t gh,
			input reading_t nl, input reading_t nh, input reading_t kl);
		cfg_write(CFG_WHITE_MAX, wmax);
		cfg_write(CFG_BROWN_LOW, bl);
		cfg_write(CFG_BROWN_HIGH, bh);
		cfg_write(CFG_GRAY_LOW, gl);
		cfg_write(CFG_GRAY_HIGH, gh);
		cfg_write(CFG_GREEN_LOW, nl);
		cfg_write(CFG_GREEN_HIGH, nh);
		cfg_write(CFG_BLACK_LOW, kl);
		cfg_write(CFG_IDX_W'(CFG_BLACK_LOW) + CFG_IDX_W'($urandom_range(1, 8)),
			reading_t'($urandom_range(0, SENSOR_MAX)));
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		settings_used++;
	endtask

	// Stops the sender and waits until every result word is back.
	task automatic settle();
		@(negedge clk);
		sensors_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		burst_left = 0;
	endtask

	// Random band: low and high drawn near each other, sometimes inverted.
	task automatic rand_band(output reading_t lo, output reading_t hi);
		int a;
		int b;
		a = $urandom_range(0, 3500);
		b = a + $urandom_range(0, 600);
		if (b > SENSOR_MAX)
			b = SENSOR_MAX;
		if ($urandom_range(0, 6) == 0) begin
			lo = reading_t'(b);
			hi = reading_t'(a);
		end else begin
			lo = reading_t'(a);
			hi = reading_t'(b);
		end
	endtask

	// Result side: switches between open, random and periodic pacing, with
	// occasional long stalls.
	always @(negedge clk) begin
		sink_tick++;
		if (mode_left == 0) begin
			mode_left = $urandom_range(20, 200);
			case ($urandom_range(0, 2))
				0: sink_mode = SINK_OPEN;
				1: sink_mode = SINK_RANDOM;
				default: sink_mode = SINK_PERIODIC;
			endcase
		end
		mode_left--;
		if (stall_left > 0) begin
			stall_left--;
			results_if.ready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_OPEN: results_if.ready <= 1'b1;
				SINK_RANDOM: results_if.ready <= ($urandom_range(0, 3) != 0);
				default: results_if.ready <= ((sink_tick % 5) < 3);
			endcase
			if ($urandom_range(0, 149) == 0)
				stall_left = $urandom_range(5, 40);
		end
	end

	// Watchdog: too many cycles in a row without any accepted word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sensors_if.valid && sensors_if.ready) ||
					(results_if.valid && results_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		sensor_set_t s;
		lcc_color_t  target;
		int          run_left;
		reading_t    bl;
		reading_t    bh;
		reading_t    gl;
		reading_t    gh;
		reading_t    nl;
		reading_t    nh;
		clk = 1'b0;
		arst_n = 1'b0;
		sensors_if.valid = 1'b0;
		sensors_if.sensor_left = '0;
		sensors_if.sensor_mid_left = '0;
		sensors_if.sensor_center = '0;
		sensors_if.sensor_mid_right = '0;
		sensors_if.sensor_right = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		results_if.ready = 1'b0;
		for (int i = 0; i < 8; i++)
			th[i] = '0;
		burst_left = 0;
		sets_sent = 0;
		settings_used = 0;
		idle_cycles = 0;
		sink_mode = SINK_OPEN;
		mode_left = 0;
		stall_left = 0;
		sink_tick = 0;
		run_left = 0;
		target = COLOR_NONE;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset thresholds: an all-zero word falls in the zero-width brown
		// band, full scale matches nothing.
		send_set(0, 0, 0, 0, 0);
		send_set(4095, 4095, 4095, 4095, 4095);
		settle();

		// Separated bands: edges of every band and each class once.
		load_thresholds(300, 400, 700, 800, 1100, 1200, 1400, 1450);
		send_set(299, 299, 299, 299, 299);
		send_set(299, 299, 300, 299, 299);
		send_set(400, 400, 400, 400, 400);
		send_set(700, 700, 700, 700, 700);
		send_set(800, 0, 0, 0, 4095);
		send_set(4095, 0, 0, 0, 1100);
		send_set(800, 2000, 2000, 2000, 1100);
		send_set(4095, 1200, 4095, 4095, 4095);
		send_set(4095, 4095, 1400, 4095, 4095);
		send_set(4095, 4095, 4095, 1500, 4095);
		send_set(4095, 4095, 4095, 1501, 4095);
		send_set(0, 1450, 0, 0, 4095);
		send_set(4095, 1450, 1300, 4095, 4095);
		send_set(800, 1300, 4095, 1450, 4095);
		// Five brown words with an unmatched one between them confirm brown.
		send_set(550, 550, 550, 550, 550);
		send_set(401, 699, 550, 402, 698);
		send_set(650, 450, 500, 600, 700);
		send_set(4095, 4095, 4095, 4095, 4095);
		send_set(400, 700, 400, 700, 400);
		send_set(555, 555, 555, 555, 555);

		// Random words under extreme, inverted and random thresholds.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			case (p)
				0: load_thresholds(0, 0, 0, 0, 0, 0, 0, 0);
				1: load_thresholds(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
				2: load_thresholds(500, 3000, 200, 3500, 100, 2500, 1000, 1501);
				default: begin
					rand_band(bl, bh);
					rand_band(gl, gh);
					rand_band(nl, nh);
					load_thresholds(reading_t'($urandom_range(0, 1200)), bl, bh, gl, gh,
						nl, nh, reading_t'($urandom_range(0, 2000)));
				end
			endcase
			for (int n = 0; n < RANDOM_SETS / RANDOM_PHASES; n++) begin
				// Runs of one target class so the history can settle.
				if (run_left == 0) begin
					target = lcc_color_t'(CODE_W'($urandom_range(0, 7)));
					run_left = $urandom_range(1, 8);
				end
				run_left--;
				build_set(target, s);
				send_set(s[0], s[1], s[2], s[3], s[4]);
			end
		end

		settle();
		$display("Run: %0d sensor words under %0d threshold settings, %0d results compared.",
			sets_sent, settings_used, checked);
		$display("Color classes produced, one bit per code: %b", classes_seen);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
